>>> design/depth_pixel_deprojection_macros.svh
// Assertion macros for the deprojection top level.
// Each macro expects clk and rst_n in scope.
`ifndef DEPTH_PIXEL_DEPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_DEPROJECTION_MACROS_SVH
`ifndef SYNTH
`define DPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpd: same-cycle check failed");
`define DPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpd: next-cycle check failed");
`else
`define DPD_ASSERT_IMP(label, ante, cons)
`define DPD_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> design/dpd_pkg.sv
package dpd_pkg;

  // pipeline layout: norm 0..4, distortion 5..17, depth scaling 18..21
  localparam int STAGES     = 22;
  localparam int NORM_LO    = 0;
  localparam int NORM_ST    = 5;
  localparam int DIST_LO    = 5;
  localparam int DIST_ST    = 13;
  localparam int SCALE_LO   = 18;
  localparam int SCALE_ST   = 4;
  localparam int DEPTH_TAPS = STAGES - 1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K12 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3  = 3'd4;

  localparam int XY_W  = 24;
  localparam int Z_W   = 16;
  localparam int OUT_W = 2 * XY_W + Z_W;

  localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
  localparam logic signed [35:0] ONE_Q28 = 36'sh0_1000_0000;

  typedef struct packed {
    logic        [31:0] inv_fx;
    logic        [31:0] inv_fy;
    logic        [31:0] cx;
    logic        [31:0] cy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } dpd_cfg_t;

  // full signed 32x32 product
  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] ae;
    logic signed [63:0] be;
    ae = {{32{a[31]}}, a};
    be = {{32{b[31]}}, b};
    return ae * be;
  endfunction

  // round half away from zero, shift right by sh, symmetric 32-bit saturate
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p,
                                                   input int unsigned sh);
    logic signed [64:0] pe;
    logic signed [64:0] bias;
    logic signed [64:0] q;
    pe   = {p[63], p};
    bias = 65'sd1 <<< (sh - 1);
    if (p[63]) begin
      bias = bias - 65'sd1;
    end
    q = (pe + bias) >>> sh;
    if (q > 65'sd2147483647) begin
      return SAT_POS;
    end else if (q < -65'sd2147483647) begin
      return -SAT_POS;
    end
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] clamp36(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return SAT_POS;
    end else if (v < -36'sd2147483647) begin
      return -SAT_POS;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [35:0] sx36(input logic signed [31:0] a);
    return {{4{a[31]}}, a};
  endfunction

endpackage

>>> design/dpd_cfg.sv
module dpd_cfg import dpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output dpd_cfg_t             cfg
);

  logic [63:0] focal_r;
  logic [63:0] principal_r;
  logic [63:0] radial_r;
  logic [63:0] tangential_r;
  logic [31:0] k3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r      <= '0;
      principal_r  <= '0;
      radial_r     <= '0;
      tangential_r <= '0;
      k3_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INV_FOCAL:  focal_r      <= cfg_data;
        REG_PRINCIPAL:  principal_r  <= cfg_data;
        REG_RADIAL_K12: radial_r     <= cfg_data;
        REG_TANGENTIAL: tangential_r <= cfg_data;
        REG_RADIAL_K3:  k3_r         <= cfg_data[31:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  assign cfg = '{
    inv_fx: focal_r[63:32],
    inv_fy: focal_r[31:0],
    cx:     principal_r[63:32],
    cy:     principal_r[31:0],
    k1:     $signed(radial_r[63:32]),
    k2:     $signed(radial_r[31:0]),
    k3:     $signed(k3_r),
    p1:     $signed(tangential_r[63:32]),
    p2:     $signed(tangential_r[31:0])
  };

endmodule

>>> design/dpd_norm.sv
module dpd_norm import dpd_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                   clk,
  input  logic [NORM_ST-1:0]     en,
  input  logic [PIXEL_BITS-1:0]  pix_col,
  input  logic [PIXEL_BITS-1:0]  pix_row,
  input  dpd_cfg_t               cfg,
  output logic signed [31:0]     norm_x,
  output logic signed [31:0]     norm_y
);

  localparam int SH_W = PIXEL_BITS + 20;
  localparam int M_W  = (SH_W > 32) ? SH_W : 32;
  localparam int D_W  = M_W + 1;
  localparam int P_W  = M_W + 16;
  localparam int S_W  = M_W + 33;

  logic [M_W-1:0] pix_sh [2];
  logic [31:0]    ctr    [2];
  logic [31:0]    rcp    [2];

  logic signed [D_W-1:0] d_r   [2];
  logic [M_W-1:0]        mag_r [2];
  logic [P_W-1:0]        hi_r  [2];
  logic [P_W-1:0]        lo_r  [2];
  logic [S_W-1:0]        sum_r [2];
  logic signed [31:0]    u_r   [2];
  logic [1:0]            neg1_r;
  logic [1:0]            neg2_r;
  logic [1:0]            neg3_r;

  always_comb begin
    pix_sh[0] = M_W'({pix_col, 20'd0});
    pix_sh[1] = M_W'({pix_row, 20'd0});
    ctr[0]    = cfg.cx;
    ctr[1]    = cfg.cy;
    rcp[0]    = cfg.inv_fx;
    rcp[1]    = cfg.inv_fy;
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic          sat;
    logic [30:0]   m31;
    logic [31:0]   mval;

    // offset from principal point, Q12.20 pixels
    always_ff @(posedge clk) begin
      if (en[0]) begin
        d_r[l] <= $signed({1'b0, pix_sh[l]}) - $signed(D_W'(ctr[l]));
      end
    end

    always_ff @(posedge clk) begin
      if (en[1]) begin
        mag_r[l]  <= d_r[l][D_W-1] ? M_W'(-d_r[l]) : M_W'(d_r[l]);
        neg1_r[l] <= d_r[l][D_W-1];
      end
    end

    // reciprocal split in halves keeps each multiplier narrow
    always_ff @(posedge clk) begin
      if (en[2]) begin
        hi_r[l]   <= P_W'(mag_r[l]) * P_W'(rcp[l][31:16]);
        lo_r[l]   <= P_W'(mag_r[l]) * P_W'(rcp[l][15:0]);
        neg2_r[l] <= neg1_r[l];
      end
    end

    always_ff @(posedge clk) begin
      if (en[3]) begin
        sum_r[l]  <= (S_W'(hi_r[l]) << 16) + S_W'(lo_r[l]) + (S_W'(1) << 21);
        neg3_r[l] <= neg2_r[l];
      end
    end

    always_comb begin
      sat  = |sum_r[l][S_W-1:53];
      m31  = sat ? 31'h7FFF_FFFF : sum_r[l][52:22];
      mval = {1'b0, m31};
    end

    always_ff @(posedge clk) begin
      if (en[4]) begin
        u_r[l] <= neg3_r[l] ? -$signed(mval) : $signed(mval);
      end
    end
  end

  assign norm_x = u_r[0];
  assign norm_y = u_r[1];

endmodule

>>> design/dpd_distort.sv
module dpd_distort import dpd_pkg::*; (
  input  logic               clk,
  input  logic [DIST_ST-1:0] en,
  input  logic signed [31:0] norm_x,
  input  logic signed [31:0] norm_y,
  input  dpd_cfg_t           cfg,
  output logic signed [31:0] ux,
  output logic signed [31:0] uy
);

  logic signed [63:0] s5_pxx_r, s5_pyy_r, s5_pxy_r;
  logic signed [31:0] s5_x_r, s5_y_r;
  logic signed [31:0] s6_xx_r, s6_yy_r, s6_xy_r, s6_x_r, s6_y_r;
  logic signed [31:0] s7_r2_r, s7_xx_r, s7_yy_r, s7_xy_r, s7_x_r, s7_y_r;
  logic signed [63:0] s8_pr4_r, s8_pk1_r;
  logic signed [31:0] s8_ax_r, s8_ay_r, s8_r2_r, s8_xy_r, s8_x_r, s8_y_r;
  logic signed [31:0] s9_r4_r, s9_k1r2_r, s9_r2_r, s9_x_r, s9_y_r;
  logic signed [63:0] s9_pt1x_r, s9_pt2x_r, s9_pt1y_r, s9_pt2y_r;
  logic signed [63:0] s10_pr6_r, s10_pk2_r;
  logic signed [31:0] s10_t1x_r, s10_t2x_r, s10_t1y_r, s10_t2y_r;
  logic signed [31:0] s10_k1r2_r, s10_x_r, s10_y_r;
  logic signed [31:0] s11_r6_r, s11_k2r4_r, s11_k1r2_r, s11_x_r, s11_y_r;
  logic signed [35:0] s11_tx_r, s11_ty_r;
  logic signed [63:0] s12_pk3_r;
  logic signed [31:0] s12_k1r2_r, s12_k2r4_r, s12_x_r, s12_y_r;
  logic signed [35:0] s12_tx_r, s12_ty_r;
  logic signed [31:0] s13_k3r6_r, s13_k1r2_r, s13_k2r4_r, s13_x_r, s13_y_r;
  logic signed [35:0] s13_tx_r, s13_ty_r;
  logic signed [31:0] s14_f_r, s14_x_r, s14_y_r;
  logic signed [35:0] s14_tx_r, s14_ty_r;
  logic signed [63:0] s15_pxf_r, s15_pyf_r;
  logic signed [35:0] s15_tx_r, s15_ty_r;
  logic signed [31:0] s16_xf_r, s16_yf_r;
  logic signed [35:0] s16_tx_r, s16_ty_r;
  logic signed [31:0] s17_ux_r, s17_uy_r;

  // squares and cross term
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s5_pxx_r <= mul32(norm_x, norm_x);
      s5_pyy_r <= mul32(norm_y, norm_y);
      s5_pxy_r <= mul32(norm_x, norm_y);
      s5_x_r   <= norm_x;
      s5_y_r   <= norm_y;
    end
  end

  // Q2.30 squared, down to Q4.28
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s6_xx_r <= round_sat(s5_pxx_r, 32);
      s6_yy_r <= round_sat(s5_pyy_r, 32);
      s6_xy_r <= round_sat(s5_pxy_r, 32);
      s6_x_r  <= s5_x_r;
      s6_y_r  <= s5_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s7_r2_r <= clamp36(sx36(s6_xx_r) + sx36(s6_yy_r));
      s7_xx_r <= s6_xx_r;
      s7_yy_r <= s6_yy_r;
      s7_xy_r <= s6_xy_r;
      s7_x_r  <= s6_x_r;
      s7_y_r  <= s6_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s8_pr4_r <= mul32(s7_r2_r, s7_r2_r);
      s8_pk1_r <= mul32(cfg.k1, s7_r2_r);
      s8_ax_r  <= clamp36(sx36(s7_r2_r) + (sx36(s7_xx_r) <<< 1));
      s8_ay_r  <= clamp36(sx36(s7_r2_r) + (sx36(s7_yy_r) <<< 1));
      s8_r2_r  <= s7_r2_r;
      s8_xy_r  <= s7_xy_r;
      s8_x_r   <= s7_x_r;
      s8_y_r   <= s7_y_r;
    end
  end

  // tangential products start here, in parallel with the radial chain
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s9_r4_r   <= round_sat(s8_pr4_r, 28);
      s9_k1r2_r <= round_sat(s8_pk1_r, 28);
      s9_pt1x_r <= mul32(cfg.p1, s8_xy_r);
      s9_pt2x_r <= mul32(cfg.p2, s8_ax_r);
      s9_pt1y_r <= mul32(cfg.p2, s8_xy_r);
      s9_pt2y_r <= mul32(cfg.p1, s8_ay_r);
      s9_r2_r   <= s8_r2_r;
      s9_x_r    <= s8_x_r;
      s9_y_r    <= s8_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s10_pr6_r  <= mul32(s9_r4_r, s9_r2_r);
      s10_pk2_r  <= mul32(cfg.k2, s9_r4_r);
      s10_t1x_r  <= round_sat(s9_pt1x_r, 28);
      s10_t2x_r  <= round_sat(s9_pt2x_r, 28);
      s10_t1y_r  <= round_sat(s9_pt1y_r, 28);
      s10_t2y_r  <= round_sat(s9_pt2y_r, 28);
      s10_k1r2_r <= s9_k1r2_r;
      s10_x_r    <= s9_x_r;
      s10_y_r    <= s9_y_r;
    end
  end

  // tangential sum kept unclamped; clamp happens once on the final sum
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s11_r6_r   <= round_sat(s10_pr6_r, 28);
      s11_k2r4_r <= round_sat(s10_pk2_r, 28);
      s11_tx_r   <= (sx36(s10_t1x_r) <<< 1) + sx36(s10_t2x_r);
      s11_ty_r   <= (sx36(s10_t1y_r) <<< 1) + sx36(s10_t2y_r);
      s11_k1r2_r <= s10_k1r2_r;
      s11_x_r    <= s10_x_r;
      s11_y_r    <= s10_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s12_pk3_r  <= mul32(cfg.k3, s11_r6_r);
      s12_k1r2_r <= s11_k1r2_r;
      s12_k2r4_r <= s11_k2r4_r;
      s12_tx_r   <= s11_tx_r;
      s12_ty_r   <= s11_ty_r;
      s12_x_r    <= s11_x_r;
      s12_y_r    <= s11_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s13_k3r6_r <= round_sat(s12_pk3_r, 28);
      s13_k1r2_r <= s12_k1r2_r;
      s13_k2r4_r <= s12_k2r4_r;
      s13_tx_r   <= s12_tx_r;
      s13_ty_r   <= s12_ty_r;
      s13_x_r    <= s12_x_r;
      s13_y_r    <= s12_y_r;
    end
  end

  // radial factor f = 1 + k1 r2 + k2 r4 + k3 r6
  always_ff @(posedge clk) begin
    if (en[9]) begin
      s14_f_r  <= clamp36(ONE_Q28 + sx36(s13_k1r2_r) + sx36(s13_k2r4_r)
                          + sx36(s13_k3r6_r));
      s14_tx_r <= s13_tx_r;
      s14_ty_r <= s13_ty_r;
      s14_x_r  <= s13_x_r;
      s14_y_r  <= s13_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s15_pxf_r <= mul32(s14_x_r, s14_f_r);
      s15_pyf_r <= mul32(s14_y_r, s14_f_r);
      s15_tx_r  <= s14_tx_r;
      s15_ty_r  <= s14_ty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s16_xf_r <= round_sat(s15_pxf_r, 30);
      s16_yf_r <= round_sat(s15_pyf_r, 30);
      s16_tx_r <= s15_tx_r;
      s16_ty_r <= s15_ty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s17_ux_r <= clamp36(sx36(s16_xf_r) + s16_tx_r);
      s17_uy_r <= clamp36(sx36(s16_yf_r) + s16_ty_r);
    end
  end

  assign ux = s17_ux_r;
  assign uy = s17_uy_r;

endmodule

>>> design/dpd_scale.sv
module dpd_scale import dpd_pkg::*; #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic [SCALE_ST-1:0]   en,
  input  logic signed [31:0]    ux,
  input  logic signed [31:0]    uy,
  input  logic [DEPTH_BITS-1:0] depth_mul,
  input  logic [DEPTH_BITS-1:0] depth_out,
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  point_valid
);

  localparam int PR_W = DEPTH_BITS + 31;
  localparam int RR_W = (DEPTH_BITS + 12 > XY_W) ? DEPTH_BITS + 12 : XY_W;
  localparam int RS_W = RR_W + 20;

  logic signed [31:0] u_in  [2];
  logic [30:0]        mag_r [2];
  logic [PR_W-1:0]    prod_r[2];
  logic [RR_W-1:0]    rr_r  [2];
  logic [XY_W-1:0]    xy_q  [2];
  logic [1:0]         neg1_r;
  logic [1:0]         neg2_r;
  logic [1:0]         neg3_r;

  logic [OUT_W-1:0]   out_tdata_r;
  logic               point_valid_r;
  logic               depth_zero;

  assign u_in[0] = ux;
  assign u_in[1] = uy;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [RS_W-1:0] rs;
    logic            sat;
    logic [XY_W-1:0] m24;

    always_ff @(posedge clk) begin
      if (en[0]) begin
        mag_r[l]  <= u_in[l][31] ? 31'(-u_in[l]) : u_in[l][30:0];
        neg1_r[l] <= u_in[l][31];
      end
    end

    always_ff @(posedge clk) begin
      if (en[1]) begin
        prod_r[l] <= PR_W'(depth_mul) * PR_W'(mag_r[l]);
        neg2_r[l] <= neg1_r[l];
      end
    end

    // Q4.28 times depth down to 8 fraction bits
    assign rs = RS_W'(prod_r[l]) + (RS_W'(1) << 19);

    always_ff @(posedge clk) begin
      if (en[2]) begin
        rr_r[l]   <= rs[RS_W-1:20];
        neg3_r[l] <= neg2_r[l];
      end
    end

    // negative side saturates one step further, to the most negative code
    always_comb begin
      sat = rr_r[l] > RR_W'(23'h7F_FFFF);
      if (sat) begin
        m24 = neg3_r[l] ? 24'h80_0000 : 24'h7F_FFFF;
      end else begin
        m24 = rr_r[l][XY_W-1:0];
      end
      xy_q[l] = neg3_r[l] ? -m24 : m24;
    end
  end

  assign depth_zero = (depth_out == '0);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_tdata_r   <= depth_zero ? '0 : {Z_W'(depth_out), xy_q[1], xy_q[0]};
      point_valid_r <= !depth_zero;
    end
  end

  assign out_tdata   = out_tdata_r;
  assign point_valid = point_valid_r;

endmodule

>>> design/depth_pixel_deprojection.sv
// Channel  Dir  Word content (low bit first)               Handshake
// -------  ---  -----------------------------------------  ----------------------
// in_      in   pixel_col, pixel_row, depth_value          in_tvalid / in_tready
// out_     out  point_x, point_y, point_z; tuser point_valid out_tvalid / out_tready
// cfg_     in   cfg_index selects register, cfg_data value  cfg_valid / cfg_ready
//
// One word per clock sustained while out_tready stays high; the pipeline holds
// 5 normalize, 13 distortion and 4 depth scale stages.
// rst_n is synchronous, active low: clears stage valid bits and the config
// registers; datapath registers are not reset.
// Backpressure: each stage loads when it is empty or its successor loads, so
// bubbles collapse; input is still taken while the output is held if a stage is empty.
// cfg_ready is always high; write config only with the pipeline empty.
`include "depth_pixel_deprojection_macros.svh"

module depth_pixel_deprojection import dpd_pkg::*; #(
  parameter int PIXEL_BITS = 12,
  parameter int DEPTH_BITS = 16,
  localparam int IN_W = ((2 * PIXEL_BITS + DEPTH_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input word
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // pixel_col, pixel_row, depth_value, zero pad
  // result word
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // point_x[23:0], point_y[47:24], point_z[63:48]
  output logic [0:0]           out_tuser,  // point_valid
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [PIXEL_BITS-1:0] in_col;
  logic [PIXEL_BITS-1:0] in_row;
  logic [DEPTH_BITS-1:0] in_depth;

  logic [STAGES-1:0]     v_r;   // word present in each stage
  logic [STAGES-1:0]     en;    // stage load enable
  logic [DEPTH_BITS-1:0] depth_r [DEPTH_TAPS];

  dpd_cfg_t              cfg;
  logic signed [31:0]    norm_x, norm_y;
  logic signed [31:0]    ux, uy;
  logic                  point_valid;

  // input field unpacking
  assign in_col   = in_tdata[PIXEL_BITS-1:0];
  assign in_row   = in_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign in_depth = in_tdata[2*PIXEL_BITS+DEPTH_BITS-1:2*PIXEL_BITS];

  // a stage may load if empty or if the next stage takes its word
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // depth rides alongside the datapath
  always_ff @(posedge clk) begin
    if (en[0]) begin
      depth_r[0] <= in_depth;
    end
    for (int i = 1; i < DEPTH_TAPS; i++) begin
      if (en[i]) begin
        depth_r[i] <= depth_r[i-1];
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[STAGES-1];
  assign out_tuser  = point_valid;
  assign cfg_ready  = 1'b1;

  dpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpd_norm #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_norm (
    .clk     (clk),
    .en      (en[NORM_LO +: NORM_ST]),
    .pix_col (in_col),
    .pix_row (in_row),
    .cfg     (cfg),
    .norm_x  (norm_x),
    .norm_y  (norm_y)
  );

  dpd_distort u_distort (
    .clk    (clk),
    .en     (en[DIST_LO +: DIST_ST]),
    .norm_x (norm_x),
    .norm_y (norm_y),
    .cfg    (cfg),
    .ux     (ux),
    .uy     (uy)
  );

  dpd_scale #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scale (
    .clk         (clk),
    .en          (en[SCALE_LO +: SCALE_ST]),
    .ux          (ux),
    .uy          (uy),
    .depth_mul   (depth_r[SCALE_LO]),
    .depth_out   (depth_r[DEPTH_TAPS-1]),
    .out_tdata   (out_tdata),
    .point_valid (point_valid)
  );

  // input only blocks when every stage is full and the output is held
  `DPD_ASSERT_IMP(a_block_only_full, !in_tready, (&v_r) && !out_tready)
  // an idle input cycle leaves a bubble in the first stage
  `DPD_ASSERT_NXT(a_bubble_enters, in_tready && !in_tvalid, !v_r[0])
  // a no-measurement point carries all-zero coordinates
  `DPD_ASSERT_IMP(a_invalid_zero, out_tvalid && !out_tuser[0], out_tdata == '0)

endmodule
